// ===== src/mev_pkg.sv =====
// ============================================================================
// Mesh element volume package
// Shared types, sizes and the tetrahedral split table of the volume block.
// ============================================================================
package mev_pkg;

   localparam int COORD_BITS_DEF   = 16;
   localparam int MAX_VERTICES_DEF = 8;
   localparam int FIELD_W          = 16;
   localparam int WHOLE_W          = 55;
   localparam int SUM_W            = 56;
   localparam int DIFF_W           = 18;
   localparam int PROD_W           = 36;
   localparam int DET_W            = 56;

   typedef enum logic [3:0] {
      ST_COLLECT,
      ST_LOAD,
      ST_DIFF,
      ST_MINOR_A,
      ST_MINOR_B,
      ST_TERM,
      ST_ACCUM,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      SHAPE_TET,
      SHAPE_PYR,
      SHAPE_PRI,
      SHAPE_HEX
   } shape_type;

   // Packed vertex ids a,b,c,d of one tetrahedron, three bits each.
   function automatic logic [11:0] tet_ids(input shape_type shape, input logic [2:0] idx);
      logic [11:0] r;
      r = 12'd0;
      case (shape)
         SHAPE_TET: r = {3'd0, 3'd1, 3'd2, 3'd3};
         SHAPE_PYR: r = (idx == 3'd0) ? {3'd0, 3'd1, 3'd2, 3'd4} : {3'd1, 3'd2, 3'd3, 3'd4};
         SHAPE_PRI: begin
            case (idx)
               3'd0:    r = {3'd0, 3'd1, 3'd2, 3'd4};
               3'd1:    r = {3'd0, 3'd2, 3'd3, 3'd4};
               default: r = {3'd2, 3'd5, 3'd3, 3'd4};
            endcase
         end
         SHAPE_HEX: begin
            case (idx)
               3'd0:    r = {3'd4, 3'd6, 3'd5, 3'd2};
               3'd1:    r = {3'd5, 3'd6, 3'd7, 3'd2};
               3'd2:    r = {3'd4, 3'd5, 3'd0, 3'd2};
               3'd3:    r = {3'd2, 3'd3, 3'd7, 3'd5};
               3'd4:    r = {3'd5, 3'd3, 3'd1, 3'd2};
               default: r = {3'd0, 3'd1, 3'd2, 3'd5};
            endcase
         end
         default: r = 12'd0;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] tet_count(input shape_type shape);
      logic [2:0] r;
      case (shape)
         SHAPE_TET: r = 3'd1;
         SHAPE_PYR: r = 3'd2;
         SHAPE_PRI: r = 3'd3;
         default:   r = 3'd6;
      endcase
      return r;
   endfunction

endpackage

// ===== src/mesh_element_volume.sv =====
// ============================================================================
// Mesh element volume
// Collects an element's vertices and sums the absolute determinants of its
// tetrahedra on one shared multiplier, then splits the sum into sixths.
// ============================================================================
//  channel   direction  ports
//  req_      in         req_valid, req_stall, req_vertex_x/y/z, req_last_vertex
//  rsp_      out        rsp_valid, rsp_stall, rsp_volume_whole/sixths, rsp_unsupported_shape
//
// A vertex word that is not final is taken with no stall.
// A final word sends each of the element's tetrahedra (one to six of them) through the
// one multiplier in turn, then divides the sum by six a byte at a time, before the
// result word is offered; an unsupported element goes straight from the load state to offering it.
// The result word waits under rsp_stall while no further word is taken.
// Reset is synchronous and clears the count, the overflow mark and the valid.
module mesh_element_volume #(
   parameter int COORD_BITS   = mev_pkg::COORD_BITS_DEF,
   parameter int MAX_VERTICES = mev_pkg::MAX_VERTICES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [mev_pkg::FIELD_W-1:0] req_vertex_x,
   input  logic signed [mev_pkg::FIELD_W-1:0] req_vertex_y,
   input  logic signed [mev_pkg::FIELD_W-1:0] req_vertex_z,
   input  logic                          req_last_vertex,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mev_pkg::WHOLE_W-1:0]   rsp_volume_whole,
   output logic [2:0]                    rsp_volume_sixths,
   output logic                          rsp_unsupported_shape
);

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int DW    = mev_pkg::DIFF_W;
   localparam int PW    = mev_pkg::PROD_W;
   localparam int TW    = mev_pkg::DET_W;
   localparam int SW    = mev_pkg::SUM_W;
   localparam int MW    = PW + DW;
   localparam int DIV_STEPS = SW / 8;
   localparam logic [9:0] RECIP_SIX = 10'd683;

   logic signed [COORD_BITS-1:0] store_x[MAX_VERTICES];
   logic signed [COORD_BITS-1:0] store_y[MAX_VERTICES];
   logic signed [COORD_BITS-1:0] store_z[MAX_VERTICES];

   mev_pkg::state_type state_ff, state_in;
   mev_pkg::shape_type shape_ff, shape_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic [2:0]       tet_ff, tet_in;
   logic [1:0]       pt_ff, pt_in;
   logic [1:0]       step_ff, step_in;
   logic [5:0]       div_ff, div_in;
   logic             unsup_ff, unsup_in;
   logic             valid_ff, valid_in;

   logic signed [COORD_BITS-1:0] va_x_ff, va_y_ff, va_z_ff;
   logic signed [COORD_BITS-1:0] vp_x_ff, vp_y_ff, vp_z_ff;
   logic signed [DW-1:0] d_ff[9];
   logic signed [PW-1:0] prod_ff, minor_ff;
   logic signed [TW-1:0] det_ff;
   logic [SW-1:0]        sum_ff;
   logic [2:0]           rem_ff;
   logic [SW-1:0]        quot_ff;

   logic [11:0]      ids;
   logic [IDX_W-1:0] rd_idx;
   logic             accept;
   logic signed [PW-1:0] mul_a;
   logic signed [DW-1:0] mul_b;
   logic signed [MW-1:0] mul_p;
   logic signed [TW-1:0] term;
   logic [10:0]          div_v;
   logic [20:0]          div_m;
   logic [7:0]           div_q;
   logic [10:0]          div_r;

   assign accept = req_valid && !req_stall;
   assign ids    = mev_pkg::tet_ids(shape_ff, tet_ff);

   always_comb begin
      case (pt_ff)
         2'd0:    rd_idx = IDX_W'(ids[11:9]);
         2'd1:    rd_idx = IDX_W'(ids[8:6]);
         2'd2:    rd_idx = IDX_W'(ids[5:3]);
         default: rd_idx = IDX_W'(ids[2:0]);
      endcase
   end

   // Vertex store, written on each taken word while it has room and read through one port.
   always_ff @(posedge clock) begin
      if (accept && state_ff == mev_pkg::ST_COLLECT && count_ff < CNT_W'(MAX_VERTICES)) begin
         store_x[count_ff[IDX_W-1:0]] <= req_vertex_x[COORD_BITS-1:0];
         store_y[count_ff[IDX_W-1:0]] <= req_vertex_y[COORD_BITS-1:0];
         store_z[count_ff[IDX_W-1:0]] <= req_vertex_z[COORD_BITS-1:0];
      end
      vp_x_ff <= store_x[rd_idx];
      vp_y_ff <= store_y[rd_idx];
      vp_z_ff <= store_z[rd_idx];
   end

   // Shared multiplier operand selection. d holds u(0..2), v(3..5), w(6..8).
   // The minor terms use step 0..1; the outer term multiplies the stored minor.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == mev_pkg::ST_TERM) begin
         mul_a = minor_ff;
         case (pt_ff)
            2'd0:    mul_b = d_ff[0];
            2'd1:    mul_b = d_ff[1];
            default: mul_b = d_ff[2];
         endcase
      end else begin
         case (step_ff)
            2'd0: begin
               case (pt_ff)
                  2'd0:    begin mul_a = PW'(d_ff[4]); mul_b = d_ff[8]; end
                  2'd1:    begin mul_a = PW'(d_ff[3]); mul_b = d_ff[8]; end
                  default: begin mul_a = PW'(d_ff[3]); mul_b = d_ff[7]; end
               endcase
            end
            default: begin
               case (pt_ff)
                  2'd0:    begin mul_a = PW'(d_ff[5]); mul_b = d_ff[7]; end
                  2'd1:    begin mul_a = PW'(d_ff[5]); mul_b = d_ff[6]; end
                  default: begin mul_a = PW'(d_ff[4]); mul_b = d_ff[6]; end
               endcase
            end
         endcase
      end
      mul_p = MW'(mul_a) * MW'(mul_b);
   end

   always_comb begin
      if (pt_ff == 2'd1) term = -TW'(mul_p);
      else term = TW'(mul_p);
   end

   // Division by six one byte per cycle; the quotient byte comes from a
   // reciprocal multiplication that is exact for every partial remainder.
   assign div_v = {rem_ff, quot_ff[SW-1 -: 8]};
   assign div_m = 21'(div_v) * 21'(RECIP_SIX);
   assign div_q = div_m[19:12];
   assign div_r = div_v - 11'(div_q) * 11'd6;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mev_pkg::ST_COLLECT: begin
            if (accept && req_last_vertex) state_in = mev_pkg::ST_LOAD;
         end
         mev_pkg::ST_LOAD: begin
            if (unsup_ff) state_in = mev_pkg::ST_DONE;
            else if (pt_ff == 2'd3) state_in = mev_pkg::ST_DIFF;
         end
         mev_pkg::ST_DIFF:    state_in = mev_pkg::ST_MINOR_A;
         mev_pkg::ST_MINOR_A: state_in = mev_pkg::ST_MINOR_B;
         mev_pkg::ST_MINOR_B: state_in = mev_pkg::ST_TERM;
         mev_pkg::ST_TERM: begin
            if (pt_ff == 2'd2) state_in = mev_pkg::ST_ACCUM;
            else state_in = mev_pkg::ST_MINOR_A;
         end
         mev_pkg::ST_ACCUM: begin
            if (tet_ff + 3'd1 == mev_pkg::tet_count(shape_ff)) state_in = mev_pkg::ST_DIVIDE;
            else state_in = mev_pkg::ST_LOAD;
         end
         mev_pkg::ST_DIVIDE: begin
            if (div_ff == 6'(DIV_STEPS - 1)) state_in = mev_pkg::ST_DONE;
         end
         mev_pkg::ST_DONE: begin
            if (!rsp_stall) state_in = mev_pkg::ST_COLLECT;
         end
         default: state_in = mev_pkg::ST_COLLECT;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      shape_in = shape_ff;
      unsup_in = unsup_ff;
      tet_in   = tet_ff;
      pt_in    = pt_ff;
      step_in  = step_ff;
      div_in   = div_ff;
      valid_in = valid_ff;
      case (state_ff)
         mev_pkg::ST_COLLECT: begin
            if (accept) begin
               if (count_ff < CNT_W'(MAX_VERTICES)) count_in = count_ff + CNT_W'(1);
               else ovf_in = 1'b1;
               if (req_last_vertex) begin
                  unsup_in = 1'b0;
                  tet_in   = 3'd0;
                  pt_in    = 2'd0;
                  if (ovf_ff || count_ff >= CNT_W'(MAX_VERTICES)) unsup_in = 1'b1;
                  else begin
                     case (count_ff + CNT_W'(1))
                        CNT_W'(4): shape_in = mev_pkg::SHAPE_TET;
                        CNT_W'(5): shape_in = mev_pkg::SHAPE_PYR;
                        CNT_W'(6): shape_in = mev_pkg::SHAPE_PRI;
                        CNT_W'(8): shape_in = mev_pkg::SHAPE_HEX;
                        default:   unsup_in = 1'b1;
                     endcase
                  end
                  if (count_ff + CNT_W'(1) == CNT_W'(8) && !ovf_ff) unsup_in = 1'b0;
               end
            end
         end
         mev_pkg::ST_LOAD: begin
            if (unsup_ff) valid_in = 1'b1;
            else pt_in = pt_ff + 2'd1;
         end
         mev_pkg::ST_DIFF: begin
            pt_in   = 2'd0;
            step_in = 2'd0;
         end
         mev_pkg::ST_MINOR_A: step_in = 2'd1;
         mev_pkg::ST_MINOR_B: step_in = 2'd0;
         mev_pkg::ST_TERM:    pt_in = (pt_ff == 2'd2) ? 2'd0 : pt_ff + 2'd1;
         mev_pkg::ST_ACCUM: begin
            tet_in = tet_ff + 3'd1;
            pt_in  = 2'd0;
            div_in = 6'd0;
         end
         mev_pkg::ST_DIVIDE: begin
            div_in = div_ff + 6'd1;
            if (div_ff == 6'(DIV_STEPS - 1)) valid_in = 1'b1;
         end
         mev_pkg::ST_DONE: begin
            if (!rsp_stall) begin
               valid_in = 1'b0;
               count_in = '0;
               ovf_in   = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mev_pkg::ST_COLLECT;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         valid_ff <= 1'b0;
         tet_ff   <= '0;
         pt_ff    <= '0;
         step_ff  <= '0;
         div_ff   <= '0;
         unsup_ff <= 1'b0;
         shape_ff <= mev_pkg::SHAPE_TET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         valid_ff <= valid_in;
         tet_ff   <= tet_in;
         pt_ff    <= pt_in;
         step_ff  <= step_in;
         div_ff   <= div_in;
         unsup_ff <= unsup_in;
         shape_ff <= shape_in;
      end
   end

   // Datapath registers. Store reads are registered, so they lag the point counter.
   always_ff @(posedge clock) begin
      if (state_ff == mev_pkg::ST_COLLECT && accept && req_last_vertex) begin
         sum_ff <= '0;
      end
      if (state_ff == mev_pkg::ST_LOAD || state_ff == mev_pkg::ST_DIFF) begin
         case (pt_ff)
            2'd1: begin
               va_x_ff <= vp_x_ff;
               va_y_ff <= vp_y_ff;
               va_z_ff <= vp_z_ff;
            end
            2'd2: begin
               d_ff[0] <= DW'(vp_x_ff) - DW'(va_x_ff);
               d_ff[1] <= DW'(vp_y_ff) - DW'(va_y_ff);
               d_ff[2] <= DW'(vp_z_ff) - DW'(va_z_ff);
            end
            2'd3: begin
               d_ff[3] <= DW'(vp_x_ff) - DW'(va_x_ff);
               d_ff[4] <= DW'(vp_y_ff) - DW'(va_y_ff);
               d_ff[5] <= DW'(vp_z_ff) - DW'(va_z_ff);
            end
            default: begin
               if (state_ff == mev_pkg::ST_DIFF) begin
                  d_ff[6] <= DW'(vp_x_ff) - DW'(va_x_ff);
                  d_ff[7] <= DW'(vp_y_ff) - DW'(va_y_ff);
                  d_ff[8] <= DW'(vp_z_ff) - DW'(va_z_ff);
                  det_ff  <= '0;
               end
            end
         endcase
      end
      if (state_ff == mev_pkg::ST_MINOR_A) prod_ff <= PW'(mul_p);
      if (state_ff == mev_pkg::ST_MINOR_B) minor_ff <= prod_ff - PW'(mul_p);
      if (state_ff == mev_pkg::ST_TERM) det_ff <= det_ff + term;
      if (state_ff == mev_pkg::ST_ACCUM) begin
         quot_ff <= sum_ff + SW'(det_ff[TW-1] ? -det_ff : det_ff);
         rem_ff  <= 3'd0;
         sum_ff  <= sum_ff + SW'(det_ff[TW-1] ? -det_ff : det_ff);
      end
      if (state_ff == mev_pkg::ST_DIVIDE) begin
         rem_ff  <= div_r[2:0];
         quot_ff <= {quot_ff[SW-9:0], div_q};
      end
   end

   assign req_stall             = (state_ff != mev_pkg::ST_COLLECT);
   assign rsp_valid             = valid_ff;
   assign rsp_unsupported_shape = unsup_ff;
   assign rsp_volume_whole      = unsup_ff ? '0 : quot_ff[mev_pkg::WHOLE_W-1:0];
   assign rsp_volume_sixths     = unsup_ff ? 3'd0 : rem_ff;

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_volume_whole))
      else $error("result word changed under stall");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("vertex taken while a result waits");
   a_sixths: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_volume_sixths < 3'd6)
      else $error("remainder out of range");
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_VERTICES))
      else $error("vertex count beyond store");

endmodule

// ===== dv/mesh_element_volume_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// Mesh element volume testbench
// Streams elements of all supported and several unsupported vertex counts
// through the block with random gaps and stalls. A predictor computes the
// expected volume of each element; a checker compares every result with it.
// ============================================================================
module mesh_element_volume_tb;

   typedef struct {
      logic [mev_pkg::WHOLE_W-1:0] whole;
      logic [2:0]                  sixths;
      logic                        unsup;
   } volume_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [mev_pkg::FIELD_W-1:0] req_vertex_x, req_vertex_y, req_vertex_z;
   logic req_last_vertex;
   logic rsp_valid;
   logic rsp_stall;
   logic [mev_pkg::WHOLE_W-1:0] rsp_volume_whole;
   logic [2:0] rsp_volume_sixths;
   logic rsp_unsupported_shape;

   volume_type expected_volumes[$];
   int failures;
   int results_seen;

   longint pts_x[8], pts_y[8], pts_z[8];
   int pt_count;
   bit pt_overflow;

   mesh_element_volume u_top (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Test completed with failures");
      $finish;
   end

   function automatic longint tet_six(int a, int b, int c, int d);
      longint ux, uy, uz, vx, vy, vz, wx, wy, wz, det;
      ux = pts_x[b] - pts_x[a]; uy = pts_y[b] - pts_y[a]; uz = pts_z[b] - pts_z[a];
      vx = pts_x[c] - pts_x[a]; vy = pts_y[c] - pts_y[a]; vz = pts_z[c] - pts_z[a];
      wx = pts_x[d] - pts_x[a]; wy = pts_y[d] - pts_y[a]; wz = pts_z[d] - pts_z[a];
      det = ux * (vy * wz - vz * wy) - uy * (vx * wz - vz * wx) + uz * (vx * wy - vy * wx);
      return (det < 0) ? -det : det;
   endfunction

   task automatic predict_volume(logic signed [15:0] x, y, z, logic last);
      longint sum;
      volume_type v;
      if (pt_count < 8) begin
         pts_x[pt_count] = x;
         pts_y[pt_count] = y;
         pts_z[pt_count] = z;
         pt_count++;
      end else begin
         pt_overflow = 1'b1;
      end
      if (last) begin
         sum = -1;
         if (!pt_overflow) begin
            case (pt_count)
               4: sum = tet_six(0, 1, 2, 3);
               5: sum = tet_six(0, 1, 2, 4) + tet_six(1, 2, 3, 4);
               6: sum = tet_six(0, 1, 2, 4) + tet_six(0, 2, 3, 4) + tet_six(2, 5, 3, 4);
               8: sum = tet_six(4, 6, 5, 2) + tet_six(5, 6, 7, 2) + tet_six(4, 5, 0, 2)
                      + tet_six(2, 3, 7, 5) + tet_six(5, 3, 1, 2) + tet_six(0, 1, 2, 5);
               default: sum = -1;
            endcase
         end
         if (sum < 0) begin
            v.whole = '0;
            v.sixths = 3'd0;
            v.unsup = 1'b1;
         end else begin
            v.whole = mev_pkg::WHOLE_W'(sum / 6);
            v.sixths = 3'(sum % 6);
            v.unsup = 1'b0;
         end
         expected_volumes.push_back(v);
         pt_count = 0;
         pt_overflow = 1'b0;
      end
   endtask

   task automatic send_vertex(logic signed [15:0] x, y, z, logic last);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 16));
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_vertex_x <= x;
      req_vertex_y <= y;
      req_vertex_z <= z;
      req_last_vertex <= last;
      do @(posedge clock); while (req_stall);
      predict_volume(x, y, z, last);
   endtask

   task automatic release_input();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   function automatic logic signed [15:0] rand_coord(int mode);
      case (mode)
         0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         1: return $signed(16'($urandom_range(0, 40))) - 16'sd20;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_element(int n, int mode);
      for (int i = 0; i < n; i++)
         send_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode), i == n - 1);
   endtask

   task automatic test_directed();
      send_vertex(16'sd0, 16'sd0, 16'sd0, 1'b0); send_vertex(16'sd1, 16'sd0, 16'sd0, 1'b0);
      send_vertex(16'sd0, 16'sd1, 16'sd0, 1'b0); send_vertex(16'sd0, 16'sd0, 16'sd1, 1'b1);
      send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
      send_vertex(16'sh7fff, 16'sh8000, 16'sh8000, 1'b0);
      send_vertex(16'sh8000, 16'sh7fff, 16'sh8000, 1'b0);
      send_vertex(16'sh8000, 16'sh8000, 16'sh7fff, 1'b1);
      send_vertex(16'sd5, 16'sd5, 16'sd5, 1'b1);
      send_element(4, 1);
      send_vertex(16'sd1, 16'sd2, 16'sd3, 1'b0); send_vertex(16'sd2, 16'sd4, 16'sd6, 1'b0);
      send_vertex(16'sd3, 16'sd6, 16'sd9, 1'b0); send_vertex(16'sd4, 16'sd8, 16'sd12, 1'b1);
   endtask

   task automatic test_shapes();
      int n;
      for (int e = 0; e < 186; e++) begin
         case ($urandom_range(0, 9))
            0: n = 4;
            1, 2: n = 5;
            3, 4: n = 6;
            5, 6, 7: n = 8;
            8: n = $urandom_range(1, 3) * 2 - 1 + ($urandom_range(0, 1) ? 0 : 6);
            default: n = $urandom_range(9, 12);
         endcase
         if (n == 4 || n == 5 || n == 6 || n == 8 || n > 8)
            send_element(n, $urandom_range(0, 2));
         else
            send_element(n, 2);
         if (e == 120) begin
            release_input();
            wait (expected_volumes.size() == 0);
         end
      end
   endtask

   initial begin
      failures = 0;
      results_seen = 0;
      pt_count = 0;
      pt_overflow = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_vertex_x = '0;
      req_vertex_y = '0;
      req_vertex_z = '0;
      req_last_vertex = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_shapes();
      release_input();
      wait (expected_volumes.size() == 0);
      repeat (500) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      int hold;
      rsp_stall = 1'b1;
      forever begin
         @(negedge clock);
         if (rsp_valid) begin
            hold = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 16));
            repeat (hold) @(negedge clock);
            rsp_stall <= 1'b0;
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      volume_type v;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_volumes.size() == 0) begin
            $error("Result word with no element pending");
            failures++;
         end else begin
            v = expected_volumes.pop_front();
            if (rsp_volume_whole !== v.whole) begin
               $error("volume_whole expected %0d got %0d", v.whole, rsp_volume_whole);
               failures++;
            end
            if (rsp_volume_sixths !== v.sixths) begin
               $error("volume_sixths expected %0d got %0d", v.sixths, rsp_volume_sixths);
               failures++;
            end
            if (rsp_unsupported_shape !== v.unsup) begin
               $error("unsupported_shape expected %0d got %0d", v.unsup,
                      rsp_unsupported_shape);
               failures++;
            end
         end
      end
   end

endmodule
